>>> rtl/dcm_pkg.sv
package dcm_pkg;

    // Raw depth sample width and the derived widths of the gamma datapath
    localparam int DEPTH_BITS  = 11;
    localparam int SQ_BITS     = 2 * DEPTH_BITS;
    localparam int CUBE_BITS   = 3 * DEPTH_BITS;
    localparam int SCALE_BITS  = CUBE_BITS + 4;          // 9 * d^3
    localparam int GAMMA_SHIFT = 3 * DEPTH_BITS - 10;    // 23 for 11-bit depth
    localparam int GAMMA_BITS  = 14;                     // max g = 9202
    localparam int POS_BITS    = 8;
    localparam int SEL_BITS    = GAMMA_BITS - POS_BITS;
    localparam int CHAN_BITS   = 8;
    localparam int OFS_BITS    = 9;

    localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'hff;

    // Ramp selector codes
    localparam logic [SEL_BITS-1:0] SEL_WHITE_RED   = 6'd0;
    localparam logic [SEL_BITS-1:0] SEL_RED_YELLOW  = 6'd1;
    localparam logic [SEL_BITS-1:0] SEL_YELLOW_GRN  = 6'd2;
    localparam logic [SEL_BITS-1:0] SEL_GRN_CYAN    = 6'd3;
    localparam logic [SEL_BITS-1:0] SEL_CYAN_BLUE   = 6'd4;
    localparam logic [SEL_BITS-1:0] SEL_BLUE_BLACK  = 6'd5;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } t_rgb;

endpackage

>>> rtl/dcm_gamma.sv
module dcm_gamma
    import dcm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [DEPTH_BITS-1:0] i_depth,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [GAMMA_BITS-1:0] o_gamma
);

    logic                  r_vld_sq, r_vld_cube, r_vld_g;
    logic [DEPTH_BITS-1:0] r_depth;
    logic [SQ_BITS-1:0]    r_sq;
    logic [CUBE_BITS-1:0]  r_cube;
    logic [GAMMA_BITS-1:0] r_g;

    logic                  stall_sq, stall_cube, stall_g;
    logic [SQ_BITS-1:0]    n_sq;
    logic [CUBE_BITS-1:0]  n_cube;
    logic [SCALE_BITS-1:0] scaled;
    logic [GAMMA_BITS-1:0] n_g;

    // A stage holds only when it carries an item and the next one holds
    assign stall_g    = r_vld_g & i_stall;
    assign stall_cube = r_vld_cube & stall_g;
    assign stall_sq   = r_vld_sq & stall_cube;
    assign o_stall    = stall_sq;

    assign n_sq   = SQ_BITS'(i_depth) * SQ_BITS'(i_depth);
    assign n_cube = CUBE_BITS'(r_sq) * CUBE_BITS'(r_depth);
    // 9 * x = (x << 3) + x
    assign scaled = (SCALE_BITS'(r_cube) << 3) + SCALE_BITS'(r_cube);
    assign n_g    = GAMMA_BITS'(scaled >> GAMMA_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_sq   <= 1'b0;
            r_vld_cube <= 1'b0;
            r_vld_g    <= 1'b0;
        end else begin
            if (!stall_sq)   r_vld_sq   <= i_valid;
            if (!stall_cube) r_vld_cube <= r_vld_sq;
            if (!stall_g)    r_vld_g    <= r_vld_cube;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall_sq && i_valid) begin
            r_depth <= i_depth;
            r_sq    <= n_sq;
        end
        if (!stall_cube && r_vld_sq) begin
            r_cube <= n_cube;
        end
        if (!stall_g && r_vld_cube) begin
            r_g <= n_g;
        end
    end

    assign o_valid = r_vld_g;
    assign o_gamma = r_g;

endmodule

>>> rtl/dcm_ramp.sv
module dcm_ramp
    import dcm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [GAMMA_BITS-1:0]      i_gamma,
    input  logic signed [OFS_BITS-1:0] i_offset,
    output logic                       o_valid,
    input  logic                       i_stall,
    output t_rgb                       o_rgb
);

    logic                 r_vld_base, r_vld_out;
    t_rgb                 r_base, r_out;
    logic                 stall_base, stall_out;
    t_rgb                 n_base, n_out;
    logic [SEL_BITS-1:0]  sel;
    logic [POS_BITS-1:0]  pos;

    assign stall_out  = r_vld_out & i_stall;
    assign stall_base = r_vld_base & stall_out;
    assign o_stall    = stall_base;

    assign sel = i_gamma[GAMMA_BITS-1:POS_BITS];
    assign pos = i_gamma[POS_BITS-1:0];

    always_comb begin
        n_base = '0;
        unique case (sel)
            SEL_WHITE_RED:  n_base = '{CHAN_MAX, CHAN_MAX - pos, CHAN_MAX - pos};
            SEL_RED_YELLOW: n_base = '{CHAN_MAX, pos, '0};
            SEL_YELLOW_GRN: n_base = '{CHAN_MAX - pos, CHAN_MAX, '0};
            SEL_GRN_CYAN:   n_base = '{'0, CHAN_MAX, pos};
            SEL_CYAN_BLUE:  n_base = '{'0, CHAN_MAX - pos, CHAN_MAX};
            SEL_BLUE_BLACK: n_base = '{'0, '0, CHAN_MAX - pos};
            default:        n_base = '0;
        endcase
    end

    function automatic logic [CHAN_BITS-1:0] sat_add(
        input logic [CHAN_BITS-1:0]       base,
        input logic signed [OFS_BITS-1:0] ofs
    );
        logic signed [CHAN_BITS+1:0] sum;
        sum = $signed({2'b00, base}) + (CHAN_BITS+2)'(ofs);
        if (sum[CHAN_BITS+1])    return '0;
        else if (sum[CHAN_BITS]) return CHAN_MAX;
        else                     return sum[CHAN_BITS-1:0];
    endfunction

    always_comb begin
        n_out.red   = sat_add(r_base.red,   i_offset);
        n_out.green = sat_add(r_base.green, i_offset);
        n_out.blue  = sat_add(r_base.blue,  i_offset);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_base <= 1'b0;
            r_vld_out  <= 1'b0;
        end else begin
            if (!stall_base) r_vld_base <= i_valid;
            if (!stall_out)  r_vld_out  <= r_vld_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall_base && i_valid)  r_base <= n_base;
        if (!stall_out && r_vld_base) r_out <= n_out;
    end

    assign o_valid = r_vld_out;
    assign o_rgb   = r_out;

endmodule

>>> rtl/depth_to_color_map_core.sv
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+------------------------------------
// depth in  | input     | i_valid / o_stall    | i_raw_depth[10:0]
// pixel out | output    | o_valid / i_stall    | o_red[7:0], o_green[7:0], o_blue[7:0]
// config    | input     | i_cfg_we (no wait)   | i_cfg_wdata[8:0] brightness offset
//
// One transaction per cycle sustained while i_stall is low; the stages from input
// acceptance to o_valid are square, cube, scale/shift, ramp lookup and offset
// saturate. The two multiplier stages set the stage depth.
// Reset (synchronous, active low) clears all stage valid bits and the offset.
// A stall holds only the stages that carry a transaction; empty stages keep
// filling, so bubbles collapse and nothing is lost or repeated.
module depth_to_color_map_core
    import dcm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // depth input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [DEPTH_BITS-1:0] i_raw_depth,
    // pixel output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CHAN_BITS-1:0]  o_red,
    output logic [CHAN_BITS-1:0]  o_green,
    output logic [CHAN_BITS-1:0]  o_blue,
    // brightness offset register
    input  logic                  i_cfg_we,
    input  logic [OFS_BITS-1:0]   i_cfg_wdata
);

    logic signed [OFS_BITS-1:0] r_offset;
    logic                       g_valid, g_stall;
    logic [GAMMA_BITS-1:0]      g_value;
    t_rgb                       rgb;

    // Offset register: the user must write it only while the pipe is idle (the
    // block itself does not enforce this), so the last stage reads it directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg_we) begin
            r_offset <= $signed(i_cfg_wdata);
        end
    end

    // Cubic gamma curve: g = (9 * d^3) >> 23 over three stages
    dcm_gamma u_gamma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_depth (i_raw_depth),
        .o_valid (g_valid),
        .i_stall (g_stall),
        .o_gamma (g_value)
    );

    // Six-segment ramp lookup, then saturating offset add
    dcm_ramp u_ramp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (g_valid),
        .o_stall  (g_stall),
        .i_gamma  (g_value),
        .i_offset (r_offset),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_rgb    (rgb)
    );

    assign o_red   = rgb.red;
    assign o_green = rgb.green;
    assign o_blue  = rgb.blue;

endmodule

>>> sim/tb_depth_to_color_map_core.sv
`timescale 1ns / 100ps

module tb_depth_to_color_map_core;
    import dcm_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int PIPE_DEPTH  = 5;        // input acceptance to o_valid
    localparam int CYCLE_LIMIT = 200_000;
    localparam int PHASE_ITEMS = 113;
    localparam int HOLD_AT     = 400;      // pixel count that starts the long hold-off
    localparam int HOLD_CYCLES = 80;

    // DUT ports, every input known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic [DEPTH_BITS-1:0] i_raw_depth = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic [CHAN_BITS-1:0]  o_red;
    logic [CHAN_BITS-1:0]  o_green;
    logic [CHAN_BITS-1:0]  o_blue;
    logic                  i_cfg_we    = 1'b0;
    logic [OFS_BITS-1:0]   i_cfg_wdata = '0;

    // Local copy of the offset register and the scoreboard
    logic signed [OFS_BITS-1:0] offset_shadow = '0;
    logic [DEPTH_BITS-1:0]      depths_pending[$];
    t_rgb                       pixels_due[$];
    int                         mismatch_count = 0;
    int                         pixels_seen    = 0;
    int                         cycle_count    = 0;

    // Idle control: a calm flag suppresses random gaps on that side
    bit src_calm  = 1'b0;
    bit sink_calm = 1'b0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // First depth of each ramp selector 1..6, found by search at startup
    logic [DEPTH_BITS-1:0] ramp_start[1:6];

    bit   depth_fire;
    t_rgb due_px;

    depth_to_color_map_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_raw_depth (i_raw_depth),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Model
    // ---------------------------------------------------------------

    // Cubic gamma: (9 * d^3) >> (3*DEPTH_BITS - 10), exact in 64 bits
    function automatic logic [GAMMA_BITS-1:0] gamma_of(input logic [DEPTH_BITS-1:0] depth);
        longint unsigned d;
        d = depth;
        return GAMMA_BITS'((64'd9 * d * d * d) >> GAMMA_SHIFT);
    endfunction

    // Add the signed offset and clamp to the channel range
    function automatic logic [CHAN_BITS-1:0] clamp_channel(input logic [CHAN_BITS-1:0] base,
                                                           input logic signed [OFS_BITS-1:0] ofs);
        int sum;
        sum = int'(base) + int'(ofs);
        if (sum < 0) return '0;
        if (sum > int'(CHAN_MAX)) return CHAN_MAX;
        return CHAN_BITS'(sum);
    endfunction

    function automatic t_rgb paint_pixel(input logic [DEPTH_BITS-1:0] depth,
                                         input logic signed [OFS_BITS-1:0] ofs);
        logic [GAMMA_BITS-1:0] gamma;
        logic [SEL_BITS-1:0]   sel;
        logic [POS_BITS-1:0]   pos;
        logic [CHAN_BITS-1:0]  r;
        logic [CHAN_BITS-1:0]  g;
        logic [CHAN_BITS-1:0]  b;
        t_rgb                  px;
        gamma = gamma_of(depth);
        sel   = gamma[GAMMA_BITS-1:POS_BITS];
        pos   = gamma[POS_BITS-1:0];
        case (sel)
            SEL_WHITE_RED: begin
                r = CHAN_MAX; g = CHAN_MAX - pos; b = CHAN_MAX - pos;
            end
            SEL_RED_YELLOW: begin
                r = CHAN_MAX; g = pos;            b = '0;
            end
            SEL_YELLOW_GRN: begin
                r = CHAN_MAX - pos; g = CHAN_MAX; b = '0;
            end
            SEL_GRN_CYAN: begin
                r = '0;       g = CHAN_MAX;       b = pos;
            end
            SEL_CYAN_BLUE: begin
                r = '0;       g = CHAN_MAX - pos; b = CHAN_MAX;
            end
            SEL_BLUE_BLACK: begin
                r = '0;       g = '0;             b = CHAN_MAX - pos;
            end
            default: begin
                // past the last ramp the pixel is black before the offset
                r = '0;       g = '0;             b = '0;
            end
        endcase
        px.red   = clamp_channel(r, ofs);
        px.green = clamp_channel(g, ofs);
        px.blue  = clamp_channel(b, ofs);
        return px;
    endfunction

    // ---------------------------------------------------------------
    // Driver: feed depths from the pending queue, idle at random
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            depth_fire = i_valid && !o_stall;
            // Predict at acceptance, with the offset that is live right now
            if (depth_fire) begin
                pixels_due.push_back(paint_pixel(i_raw_depth, offset_shadow));
            end
            // Hold a stalled transaction; otherwise advance or drop valid
            if (!i_valid || depth_fire) begin
                if (depths_pending.size() != 0 && (src_calm || $urandom_range(99) >= 10)) begin
                    i_valid     <= 1'b1;
                    i_raw_depth <= depths_pending.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: check each pixel against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                pixels_seen++;
                if (pixels_due.size() == 0) begin
                    $error("unexpected pixel: red %0d green %0d blue %0d", o_red, o_green, o_blue);
                    mismatch_count++;
                end else begin
                    due_px = pixels_due.pop_front();
                    if (o_red !== due_px.red) begin
                        $error("red mismatch: expected %0d, actual %0d", due_px.red, o_red);
                        mismatch_count++;
                    end
                    if (o_green !== due_px.green) begin
                        $error("green mismatch: expected %0d, actual %0d", due_px.green, o_green);
                        mismatch_count++;
                    end
                    if (o_blue !== due_px.blue) begin
                        $error("blue mismatch: expected %0d, actual %0d", due_px.blue, o_blue);
                        mismatch_count++;
                    end
                end
            end
            // Once, hold off for a long stretch so the pipe fills and stalls the input
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (pixels_seen == HOLD_AT && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= !sink_calm && ($urandom_range(99) < 10);
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog
    // ---------------------------------------------------------------
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------

    // Wait until every queued depth is accepted and every pixel checked,
    // then let the pipe run empty before touching the register
    task automatic drain(input int tail_cycles);
        while (depths_pending.size() != 0 || i_valid || pixels_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (tail_cycles) @(posedge i_clk);
    endtask

    task automatic write_offset(input logic [OFS_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        offset_shadow = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= ~value;
    endtask

    // Mostly depths that land on a ramp; some across the whole range,
    // some around ramp edges, some at the extremes
    function automatic logic [DEPTH_BITS-1:0] pick_depth();
        int                    mode;
        logic [DEPTH_BITS-1:0] edge_depth;
        mode = $urandom_range(9);
        case (mode)
            6, 7: return DEPTH_BITS'($urandom_range((1 << DEPTH_BITS) - 1));
            8: begin
                edge_depth = ramp_start[$urandom_range(6, 1)];
                return edge_depth + DEPTH_BITS'($urandom_range(4)) - DEPTH_BITS'(2);
            end
            9: begin
                if ($urandom_range(1))
                    return DEPTH_BITS'($urandom_range(15));
                return DEPTH_BITS'((1 << DEPTH_BITS) - 1 - $urandom_range(15));
            end
            default: return DEPTH_BITS'($urandom_range(int'(ramp_start[6])));
        endcase
    endfunction

    task automatic queue_random(input int count);
        repeat (count) depths_pending.push_back(pick_depth());
    endtask

    initial begin
        logic [OFS_BITS-1:0] offset_plan[10];
        int                  sel_want;
        int                  d;

        // Locate the first depth of each ramp selector
        sel_want = 1;
        for (d = 0; d < (1 << DEPTH_BITS) && sel_want <= 6; d++) begin
            if (gamma_of(DEPTH_BITS'(d)) >= GAMMA_BITS'(sel_want << POS_BITS)) begin
                ramp_start[sel_want] = DEPTH_BITS'(d);
                sel_want++;
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: range extremes and both sides of every ramp edge, reset offset
        depths_pending.push_back('0);
        depths_pending.push_back(DEPTH_BITS'(1));
        depths_pending.push_back(DEPTH_BITS'(255));
        depths_pending.push_back(DEPTH_BITS'(512));
        depths_pending.push_back(DEPTH_BITS'(1024));
        depths_pending.push_back(DEPTH_BITS'((1 << DEPTH_BITS) - 2));
        depths_pending.push_back(DEPTH_BITS'((1 << DEPTH_BITS) - 1));
        for (int s = 1; s <= 6; s++) begin
            depths_pending.push_back(ramp_start[s] - DEPTH_BITS'(1));
            depths_pending.push_back(ramp_start[s]);
        end
        drain(2 * PIPE_DEPTH);

        // Offset settings: nominal range ends, full 9-bit extremes, zero,
        // unit steps and random values
        offset_plan[0] = OFS_BITS'(128);
        offset_plan[1] = OFS_BITS'(-128);
        offset_plan[2] = OFS_BITS'(255);
        offset_plan[3] = OFS_BITS'(-256);
        offset_plan[4] = '0;
        offset_plan[5] = OFS_BITS'(1);
        offset_plan[6] = OFS_BITS'(-1);
        for (int k = 7; k < 10; k++) offset_plan[k] = OFS_BITS'($urandom_range(511));

        for (int k = 0; k < 10; k++) begin
            write_offset(offset_plan[k]);
            // One phase runs back to back with no idling on either side
            src_calm  = (k == 4);
            sink_calm = (k == 4);
            queue_random(PHASE_ITEMS);
            drain(2 * PIPE_DEPTH);
        end
        src_calm  = 1'b0;
        sink_calm = 1'b0;

        // Give any stray late pixel the chance to show up
        drain(4 * PIPE_DEPTH);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
